/* hdl/bilinear_table_interpolator_defines.svh */
// Assertion macros shared by the interpolator.
`ifndef BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH
`define BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH

// Implication checked on every clock edge while out of reset.
`define BTI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define BTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/bti_pkg.sv */
package bti_pkg;
    localparam logic [1:0] ACT_WRITE_WL    = 2'd0;
    localparam logic [1:0] ACT_WRITE_ANGLE = 2'd1;
    localparam logic [1:0] ACT_WRITE_ENTRY = 2'd2;
    localparam logic [1:0] ACT_QUERY       = 2'd3;

    localparam logic [1:0] CFG_WL_COUNT    = 2'd0;
    localparam logic [1:0] CFG_ANGLE_COUNT = 2'd1;
    localparam logic [1:0] CFG_TABLE_READY = 2'd2;

    localparam int WL_W    = 20;
    localparam int ANG_W   = 16;
    localparam int ENTRY_W = 18;
    localparam int EFF_W   = 17;
    localparam int FRAC_W  = 17;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLAMP,
        CMD_SEARCH_RD,
        CMD_SEARCH_CMP,
        CMD_CELL_RD,
        CMD_CELL_LATCH,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_CORNER_RD,
        CMD_CORNER_ACC,
        CMD_MUL_A,
        CMD_MUL_B,
        CMD_FINISH
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t    cmd;
        logic       axis;     // 0 wavelength, 1 angle
        logic [1:0] corner;   // corner for table reads
    } dp_ctrl_t;

    typedef struct packed {
        logic search_done;
        logic div_done;
    } dp_stat_t;
endpackage

/* hdl/bilinear_table_interpolator.sv */
// Bilinear interpolator over a non-uniform wavelength/angle grid. Write
// requests (actions 0..2) complete at the edge that accepts them and never
// raise busy. A query runs two binary searches through the grid memory (a
// read and a compare state per step) and two 17-step restoring divisions
// on one shared divider, plus four corner multiply-accumulates. A query
// with table_ready low answers in the next cycle. The result appears on
// efficiency for exactly one cycle with result_valid high; the receiver
// cannot stall it. After reset the table memory is cleared one entry per
// cycle with busy high; configuration writes are taken anytime.
module bilinear_table_interpolator
    import bti_pkg::*;
#(
    parameter int MAX_WAVELENGTHS = 64,
    parameter int MAX_ANGLES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                action,
    input  logic [5:0]                row_index,
    input  logic [5:0]                column_index,
    input  logic [WL_W-1:0]           wavelength_in,
    input  logic signed [ANG_W-1:0]   angle_in,
    input  logic signed [ENTRY_W-1:0] entry_value,
    output logic                      result_valid,
    output logic [EFF_W-1:0]          efficiency,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [6:0]                cfg_data
);
    `include "bilinear_table_interpolator_defines.svh"

    localparam int TA = $clog2(MAX_WAVELENGTHS * MAX_ANGLES);

    logic [6:0] wl_count_reg, ang_count_reg;
    logic       ready_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_count_reg  <= 7'd2;
            ang_count_reg <= 7'd2;
            ready_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WL_COUNT:    wl_count_reg  <= cfg_data;
                CFG_ANGLE_COUNT: ang_count_reg <= cfg_data;
                CFG_TABLE_READY: ready_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic wr_en, done, zero_out, clear_en;
    logic [TA-1:0] clear_addr;
    logic [EFF_W-1:0] dp_result;

    bti_controller #(.TA(TA)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action),
        .table_ready(ready_reg), .stat(stat), .ctrl(ctrl), .busy(busy),
        .wr_en(wr_en), .done(done), .zero_out(zero_out),
        .clear_en(clear_en), .clear_addr(clear_addr));

    bti_datapath #(.MAX_WAVELENGTHS(MAX_WAVELENGTHS), .MAX_ANGLES(MAX_ANGLES)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat), .wr_en(wr_en),
        .wr_action(action), .row_index(row_index), .column_index(column_index),
        .wavelength_in(wavelength_in), .angle_in(angle_in),
        .entry_value(entry_value), .wavelength_count(wl_count_reg),
        .angle_count(ang_count_reg), .clear_en(clear_en),
        .clear_addr(clear_addr), .result(dp_result));

    assign result_valid = done;
    assign efficiency   = zero_out ? '0 : dp_result;

    // A result never exceeds 1.0, an accepted write is not followed by a result, and clearing implies busy.
    `BTI_ASSERT_IMPL(a_eff_range, result_valid, efficiency <= ONE_Q16)
    `BTI_ASSERT_NEXT(a_write_no_result, start && !busy && action != ACT_QUERY,
        !result_valid)
    `BTI_ASSERT_IMPL(a_clear_busy, clear_en, busy)
endmodule

/* hdl/bti_ram.sv */
// Generic RAM with one write port and one registered read port.
module bti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/bti_datapath.sv */
module bti_datapath
    import bti_pkg::*;
#(
    parameter int MAX_WAVELENGTHS = 64,
    parameter int MAX_ANGLES = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_ctrl_t                ctrl,
    output dp_stat_t                stat,
    input  logic                    wr_en,
    input  logic [1:0]              wr_action,
    input  logic [5:0]              row_index,
    input  logic [5:0]              column_index,
    input  logic [WL_W-1:0]         wavelength_in,
    input  logic signed [ANG_W-1:0] angle_in,
    input  logic signed [ENTRY_W-1:0] entry_value,
    input  logic [6:0]              wavelength_count,
    input  logic [6:0]              angle_count,
    input  logic                    clear_en,
    input  logic [$clog2(MAX_WAVELENGTHS*MAX_ANGLES)-1:0] clear_addr,
    output logic [EFF_W-1:0]        result
);
    localparam int WA = $clog2(MAX_WAVELENGTHS);
    localparam int AA = $clog2(MAX_ANGLES);
    localparam int TA = WA + AA;
    localparam int NWB = $clog2(MAX_WAVELENGTHS + 1);
    localparam int NAB = $clog2(MAX_ANGLES + 1);
    localparam int IB = (NWB > NAB) ? NWB : NAB;
    localparam int VW = 21;   // common signed width for both axes

    // Effective counts, clamped to [2, MAX].
    logic [IB-1:0] nw, na, n_sel;
    always_comb
    begin
        if (wavelength_count < 7'd2)
            nw = IB'(2);
        else if (32'(wavelength_count) > MAX_WAVELENGTHS)
            nw = IB'(MAX_WAVELENGTHS);
        else
            nw = IB'(wavelength_count);
        if (angle_count < 7'd2)
            na = IB'(2);
        else if (32'(angle_count) > MAX_ANGLES)
            na = IB'(MAX_ANGLES);
        else
            na = IB'(angle_count);
        n_sel = ctrl.axis ? na : nw;
    end

    // Grid and table memories.
    logic [WA-1:0] wl_raddr;
    logic [AA-1:0] ang_raddr;
    logic [TA-1:0] tab_raddr;
    logic [WL_W-1:0] wl_rdata;
    logic [ANG_W-1:0] ang_rdata;
    logic [ENTRY_W-1:0] tab_rdata;
    logic wl_we, ang_we, tab_we;
    logic [TA-1:0] tab_waddr;
    logic [ENTRY_W-1:0] tab_wdata;

    assign wl_we  = wr_en && wr_action == ACT_WRITE_WL
                    && 32'(column_index) < MAX_WAVELENGTHS;
    assign ang_we = wr_en && wr_action == ACT_WRITE_ANGLE
                    && 32'(row_index) < MAX_ANGLES;
    assign tab_we = clear_en || (wr_en && wr_action == ACT_WRITE_ENTRY
                    && 32'(row_index) < MAX_ANGLES
                    && 32'(column_index) < MAX_WAVELENGTHS);
    assign tab_waddr = clear_en ? clear_addr
                     : TA'((32'(row_index) * MAX_WAVELENGTHS) + 32'(column_index));
    assign tab_wdata = clear_en ? '0 : entry_value;

    bti_ram #(.WIDTH(WL_W), .DEPTH(MAX_WAVELENGTHS)) u_wl_ram (
        .clk(clk), .we(wl_we), .waddr(WA'(column_index)), .wdata(wavelength_in),
        .raddr(wl_raddr), .rdata(wl_rdata));
    bti_ram #(.WIDTH(ANG_W), .DEPTH(MAX_ANGLES)) u_ang_ram (
        .clk(clk), .we(ang_we), .waddr(AA'(row_index)), .wdata(angle_in),
        .raddr(ang_raddr), .rdata(ang_rdata));
    bti_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WAVELENGTHS*MAX_ANGLES)) u_tab_ram (
        .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(tab_rdata));

    // Grid read data in the common signed width.
    logic signed [VW-1:0] g_rd;
    assign g_rd = ctrl.axis ? VW'(signed'(ang_rdata)) : VW'({1'b0, wl_rdata});

    // Query and search registers.
    logic signed [VW-1:0] qx_reg, qy_reg, x_reg;
    logic signed [VW-1:0] lo_reg;
    logic [IB-1:0] first_reg, count_reg, idx_reg;
    logic [IB-1:0] iw_reg, ia_reg;
    logic [1:0] phase_reg;
    logic edge_lo_reg, edge_hi_reg;
    logic [IB-1:0] step;
    assign step = count_reg >> 1;

    // Query value of the current axis clamped to the first and last grid points.
    logic signed [VW-1:0] q_sel, x_clamp;
    always_comb
    begin
        q_sel = ctrl.axis ? qy_reg : qx_reg;
        if (q_sel < lo_reg)
            x_clamp = lo_reg;
        else if (q_sel > g_rd)
            x_clamp = g_rd;
        else
            x_clamp = q_sel;
    end

    logic [IB-1:0] gaddr;
    always_comb
    begin
        gaddr = '0;
        unique case (ctrl.cmd)
            CMD_CLAMP:      gaddr = (phase_reg == 2'd0) ? '0 : n_sel - IB'(1);
            CMD_SEARCH_RD:  gaddr = first_reg + step;
            CMD_CELL_RD:    gaddr = (phase_reg == 2'd1) ? idx_reg : idx_reg + IB'(1);
            default:        gaddr = '0;
        endcase
    end
    assign wl_raddr  = WA'(gaddr);
    assign ang_raddr = AA'(gaddr);

    // Cell bounds and divider.
    logic signed [VW-1:0] a_reg, b_reg;
    logic [VW:0] rem_reg, den_reg;
    logic [FRAC_W-1:0] quo_reg;
    logic [4:0] div_cnt_reg;
    logic [FRAC_W-1:0] tx_reg, ty_reg;
    logic [VW:0] rem_sh;
    assign rem_sh = {rem_reg[VW-1:0], 1'b0};

    // Table address for each corner.
    logic [IB-1:0] ci, cr;
    assign ci = iw_reg + IB'(ctrl.corner[0]);
    assign cr = ia_reg + IB'(ctrl.corner[1]);
    assign tab_raddr = TA'((32'(cr) * MAX_WAVELENGTHS) + 32'(ci));

    // Weighted accumulation: weight then weight*entry per corner.
    logic [FRAC_W-1:0] wx, wy;
    assign wx = ctrl.corner[0] ? tx_reg : ONE_Q16 - tx_reg;
    assign wy = ctrl.corner[1] ? ty_reg : ONE_Q16 - ty_reg;
    logic [33:0] wgt_reg;
    logic signed [ENTRY_W-1:0] ent_reg;
    logic signed [53:0] acc_reg;
    logic signed [52:0] prod;
    logic [16:0] wlo;
    logic [16:0] whi;
    logic signed [36:0] plo_reg, phi_reg;
    assign wlo = wgt_reg[16:0];
    assign whi = wgt_reg[33:17];
    assign prod = 53'(phi_reg) * 53'sd131072 + 53'(plo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            unique case (ctrl.cmd)
                CMD_LOAD:
                begin
                    qx_reg    <= VW'({1'b0, wavelength_in});
                    qy_reg    <= VW'(angle_in);
                    phase_reg <= '0;
                    acc_reg   <= '0;
                end
                CMD_CLAMP:
                begin
                    // phase 0 issues read of g[0]; 1 latches lo, reads g[n-1];
                    // 2 clamps against g[n-1] as read.
                    if (phase_reg == 2'd1)
                        lo_reg <= g_rd;
                    if (phase_reg == 2'd2)
                    begin
                        x_reg <= x_clamp;
                        // A value at the first point takes the first cell, one at
                        // the last point the last cell; the search result is unused.
                        edge_lo_reg <= (x_clamp <= lo_reg);
                        edge_hi_reg <= (x_clamp >= g_rd);
                        first_reg <= '0;
                        count_reg <= n_sel;
                        phase_reg <= '0;
                    end
                    else
                        phase_reg <= phase_reg + 2'd1;
                end
                CMD_SEARCH_RD:
                    phase_reg <= '0;
                CMD_SEARCH_CMP:
                begin
                    if (!(x_reg < g_rd))
                    begin
                        first_reg <= first_reg + step + IB'(1);
                        count_reg <= count_reg - step - IB'(1);
                    end
                    else
                        count_reg <= step;
                end
                CMD_CELL_RD:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        // Grid ends first, otherwise first-1 clamped to [0, n-2].
                        if (edge_lo_reg)
                            idx_reg <= '0;
                        else if (edge_hi_reg)
                            idx_reg <= n_sel - IB'(2);
                        else if (first_reg == '0)
                            idx_reg <= '0;
                        else if (first_reg - IB'(1) > n_sel - IB'(2))
                            idx_reg <= n_sel - IB'(2);
                        else
                            idx_reg <= first_reg - IB'(1);
                        phase_reg <= 2'd1;
                    end
                    else if (phase_reg == 2'd1)
                        phase_reg <= 2'd2;
                    else
                    begin
                        a_reg     <= g_rd;
                        phase_reg <= 2'd3;
                    end
                end
                CMD_CELL_LATCH:
                begin
                    b_reg     <= g_rd;
                    phase_reg <= '0;
                end
                CMD_DIV_INIT:
                begin
                    if (!(b_reg > a_reg))
                    begin
                        den_reg <= '0;
                        rem_reg <= '0;
                    end
                    else
                    begin
                        den_reg <= (VW+1)'(b_reg) - (VW+1)'(a_reg);
                        if (x_reg < a_reg)
                            rem_reg <= '0;
                        else if (x_reg - a_reg > b_reg - a_reg)
                            rem_reg <= (VW+1)'(b_reg) - (VW+1)'(a_reg);
                        else
                            rem_reg <= (VW+1)'(x_reg) - (VW+1)'(a_reg);
                    end
                    quo_reg     <= '0;
                    div_cnt_reg <= '0;
                    if (ctrl.axis)
                        ia_reg <= idx_reg;
                    else
                        iw_reg <= idx_reg;
                end
                CMD_DIV_STEP:
                begin
                    // Restoring division of num*2^16 by den, one bit a step.
                    if (den_reg == '0)
                        quo_reg <= '0;
                    else if (div_cnt_reg == 5'd0)
                    begin
                        if (rem_reg >= den_reg)
                        begin
                            quo_reg <= 17'd1;
                            rem_reg <= rem_reg - den_reg;
                        end
                        else
                            quo_reg <= '0;
                    end
                    else if (rem_sh >= den_reg)
                    begin
                        quo_reg <= {quo_reg[FRAC_W-2:0], 1'b1};
                        rem_reg <= rem_sh - den_reg;
                    end
                    else
                    begin
                        quo_reg <= {quo_reg[FRAC_W-2:0], 1'b0};
                        rem_reg <= rem_sh;
                    end
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd16)
                    begin
                        if (ctrl.axis)
                            ty_reg <= (den_reg == '0) ? '0 : {quo_reg[FRAC_W-2:0],
                                      (rem_sh >= den_reg)};
                        else
                            tx_reg <= (den_reg == '0) ? '0 : {quo_reg[FRAC_W-2:0],
                                      (rem_sh >= den_reg)};
                    end
                end
                CMD_CORNER_RD:
                    wgt_reg <= 34'(wx) * 34'(wy);
                CMD_MUL_A:
                    ent_reg <= signed'(tab_rdata);
                CMD_MUL_B:
                begin
                    plo_reg <= 37'(signed'({1'b0, wlo})) * 37'(ent_reg);
                    phi_reg <= 37'(signed'({1'b0, whi})) * 37'(ent_reg);
                end
                CMD_CORNER_ACC:
                    acc_reg <= acc_reg + 54'(prod);
                default:
                begin
                end
            endcase
        end
    end

    assign stat.search_done = (count_reg == '0);
    assign stat.div_done    = (div_cnt_reg == 5'd17);

    // Final rounding and clamping.
    always_comb
    begin
        if (acc_reg <= 0)
            result = '0;
        else if (acc_reg >= (54'sd65536 <<< 32))
            result = ONE_Q16;
        else
            result = EFF_W'((acc_reg + (54'sd1 <<< 31)) >>> 32);
    end
endmodule

/* hdl/bti_controller.sv */
module bti_controller
    import bti_pkg::*;
#(
    parameter int TA = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    action,
    input  logic          table_ready,
    input  dp_stat_t      stat,
    output dp_ctrl_t      ctrl,
    output logic          busy,
    output logic          wr_en,
    output logic          done,
    output logic          zero_out,
    output logic          clear_en,
    output logic [TA-1:0] clear_addr
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CLAMP, S_SRD, S_SCMP, S_CELL, S_CLATCH,
        S_DINIT, S_DSTEP, S_CRD, S_MA, S_MB, S_ACC, S_DONE
    } state_t;

    state_t state_reg;
    logic axis_reg;
    logic [1:0] corner_reg;
    logic [1:0] cnt_reg;
    logic [TA-1:0] clr_reg;
    logic done_reg, zero_reg;

    assign busy       = (state_reg != S_IDLE);
    assign wr_en      = (state_reg == S_IDLE) && start && action != ACT_QUERY;
    assign done       = done_reg;
    assign zero_out   = zero_reg;
    assign clear_en   = (state_reg == S_CLEAR);
    assign clear_addr = clr_reg;

    // Command decode per state.
    always_comb
    begin
        ctrl.axis   = axis_reg;
        ctrl.corner = corner_reg;
        unique case (state_reg)
            S_IDLE:   ctrl.cmd = (start && action == ACT_QUERY) ? CMD_LOAD : CMD_NONE;
            S_CLAMP:  ctrl.cmd = CMD_CLAMP;
            S_SRD:    ctrl.cmd = CMD_SEARCH_RD;
            S_SCMP:   ctrl.cmd = CMD_SEARCH_CMP;
            S_CELL:   ctrl.cmd = CMD_CELL_RD;
            S_CLATCH: ctrl.cmd = CMD_CELL_LATCH;
            S_DINIT:  ctrl.cmd = CMD_DIV_INIT;
            S_DSTEP:  ctrl.cmd = CMD_DIV_STEP;
            S_CRD:    ctrl.cmd = CMD_CORNER_RD;
            S_MA:     ctrl.cmd = CMD_MUL_A;
            S_MB:     ctrl.cmd = CMD_MUL_B;
            S_ACC:    ctrl.cmd = CMD_CORNER_ACC;
            S_DONE:   ctrl.cmd = CMD_FINISH;
            default:  ctrl.cmd = CMD_NONE;
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            axis_reg   <= 1'b0;
            corner_reg <= '0;
            cnt_reg    <= '0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            zero_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + TA'(1);
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (start && action == ACT_QUERY)
                    begin
                        if (!table_ready)
                        begin
                            done_reg <= 1'b1;
                            zero_reg <= 1'b1;
                        end
                        else
                        begin
                            axis_reg  <= 1'b0;
                            cnt_reg   <= '0;
                            state_reg <= S_CLAMP;
                        end
                    end
                S_CLAMP:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SRD;
                    end
                end
                S_SRD:
                    state_reg <= S_SCMP;
                S_SCMP:
                    state_reg <= S_SRD;
                S_CELL:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_CLATCH;
                    end
                end
                S_CLATCH:
                    state_reg <= S_DINIT;
                S_DINIT:
                    state_reg <= S_DSTEP;
                S_DSTEP:
                    if (stat.div_done)
                    begin
                        if (!axis_reg)
                        begin
                            axis_reg  <= 1'b1;
                            state_reg <= S_CLAMP;
                        end
                        else
                        begin
                            corner_reg <= '0;
                            state_reg  <= S_CRD;
                        end
                    end
                S_CRD:
                    state_reg <= S_MA;
                S_MA:
                    state_reg <= S_MB;
                S_MB:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    corner_reg <= corner_reg + 2'd1;
                    state_reg  <= (corner_reg == 2'd3) ? S_DONE : S_CRD;
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            // Search loop exit once the range is empty.
            if (state_reg == S_SRD && stat.search_done)
                state_reg <= S_CELL;
        end
    end
endmodule
